/* sv/ecbb_pkg.sv */
// ----------------------------------------------------------------------------
// ecbb_pkg
// Shared constants and types for the edge-clipped box blur.
// ----------------------------------------------------------------------------
package ecbb_pkg;

  localparam int MAX_SIDE    = 256;
  localparam int MAX_WINDOW  = 64;
  localparam int HEIGHT_BITS = 16;
  localparam int STORE_ROWS  = MAX_WINDOW + 1;
  localparam int COL_BITS    = $clog2(MAX_SIDE);
  localparam int RMOD_BITS   = $clog2(STORE_ROWS);
  localparam int ADDR_BITS   = RMOD_BITS + COL_BITS;
  localparam int DEPTH       = STORE_ROWS * MAX_SIDE;
  localparam int SIDE_BITS   = 9;
  localparam int WIN_BITS    = 7;
  localparam int POS_BITS    = 17;
  localparam int CNT_BITS    = 13;
  localparam int DEN_BITS    = CNT_BITS + 1;
  localparam int SUM_BITS    = HEIGHT_BITS + 2 * $clog2(MAX_WINDOW) + 1;
  localparam int NUM_BITS    = SUM_BITS + 1;
  localparam int MAG_BITS    = NUM_BITS - 1;
  localparam int STEP_BITS   = $clog2(MAG_BITS);

  localparam logic CFG_SIDE   = 1'b0;
  localparam logic CFG_WINDOW = 1'b1;
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SUM  = 5'b00010,
    S_LAST = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

endpackage

/* sv/ecbb_line_ram.sv */
// ----------------------------------------------------------------------------
// ecbb_line_ram
// Circular line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ecbb_line_ram import ecbb_pkg::*; (
  input  logic                          clk,
  input  logic                          we,
  input  logic [ADDR_BITS-1:0]          waddr,
  input  logic signed [HEIGHT_BITS-1:0] wdata,
  input  logic                          re,
  input  logic [ADDR_BITS-1:0]          raddr,
  output logic signed [HEIGHT_BITS-1:0] rdata
);

  logic signed [HEIGHT_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/ecbb_div.sv */
// ----------------------------------------------------------------------------
// ecbb_div
// Serial restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module ecbb_div import ecbb_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [NUM_BITS-1:0]    num,
  input  logic [DEN_BITS-1:0]           den,
  output logic                          done,
  output logic signed [HEIGHT_BITS-1:0] quot
);

  logic [MAG_BITS-1:0]  mag;
  logic [DEN_BITS-1:0]  rem;
  logic [DEN_BITS:0]    trial;
  logic [DEN_BITS-1:0]  dvs;
  logic                 neg;
  logic                 busy;
  logic [STEP_BITS-1:0] step;
  logic                 ge;
  logic [NUM_BITS-1:0]  num_abs;

  assign num_abs = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
  assign trial   = {rem, mag[MAG_BITS-1]};
  assign ge      = trial >= {1'b0, dvs};
  assign quot    = neg ? HEIGHT_BITS'(-mag[HEIGHT_BITS-1:0]) : mag[HEIGHT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_BITS'(MAG_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag <= num_abs[MAG_BITS-1:0];
      neg <= num[NUM_BITS-1];
      rem <= '0;
      dvs <= den;
    end else if (busy) begin
      rem <= ge ? DEN_BITS'(trial - {1'b0, dvs}) : trial[DEN_BITS-1:0];
      mag <= {mag[MAG_BITS-2:0], ge};
    end
  end

endmodule

/* sv/edge_clipped_box_blur_core.sv */
// ----------------------------------------------------------------------------
// edge_clipped_box_blur_core
// Raster-order box blur with window clipped to the grid and rounded mean.
// Sequence: an emitting request reads n cells from the line store,
//   n = cells in the clipped window (one line store read per cycle), then
//   runs 29 serial divider steps and hands the result to the output.
// Requests: one at a time; a non-emitting request does not hold the input,
//   an emitting one holds it until its result enters the output register.
// Reset: side 256, window 40, frame restarted; line store is not cleared.
// ----------------------------------------------------------------------------
module edge_clipped_box_blur_core import ecbb_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [SIDE_BITS-1:0]          cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic signed [HEIGHT_BITS-1:0] height,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [HEIGHT_BITS-1:0] smoothed,
  output logic [7:0]                    row,
  output logic [7:0]                    column,
  output logic                          frame_end
);

  state_t state;
  logic [SIDE_BITS-1:0] side_length;
  logic [WIN_BITS-1:0]  window_width;
  logic [SIDE_BITS-1:0] side_eff, side_m1;
  logic [WIN_BITS-1:0]  win_eff;
  logic [5:0]           lo, hi;
  logic [POS_BITS-1:0]  total, delay;

  logic [POS_BITS-1:0]  in_pos, out_pos;
  logic                 draining;
  logic [COL_BITS-1:0]  in_c, out_r, out_c;
  logic [RMOD_BITS-1:0] in_rmod, out_rmod;

  logic [RMOD_BITS-1:0] cur_rmod;
  logic [COL_BITS-1:0]  cur_c, c_lo, c_hi;
  logic [6:0]           rows_left;
  logic [CNT_BITS-1:0]  cnt;
  logic signed [SUM_BITS-1:0] acc;
  logic                 rd_valid, div_go, div_done;
  logic signed [HEIGHT_BITS-1:0] rdata, quot;

  logic in_fire, take, start_emit, last_out;
  logic [COL_BITS-1:0]  r0, r1, c0, c1;
  logic [SIDE_BITS-1:0] r_hi, c_hi_raw;
  logic [RMOD_BITS-1:0] r0mod;
  logic [6:0]           nrows, ncols;
  logic [13:0]          area;
  logic signed [NUM_BITS-1:0] num;

  always_comb begin
    side_eff = side_length;
    if (side_length == '0) side_eff = SIDE_BITS'(1);
    else if (side_length > SIDE_BITS'(MAX_SIDE)) side_eff = SIDE_BITS'(MAX_SIDE);
    win_eff = window_width;
    if (window_width == '0) win_eff = WIN_BITS'(1);
    else if (window_width > WIN_BITS'(MAX_WINDOW)) win_eff = WIN_BITS'(MAX_WINDOW);
  end

  assign side_m1 = side_eff - 1'b1;
  assign lo      = win_eff[6:1];
  assign hi      = 6'(win_eff - 7'd1 - {1'b0, lo});
  assign total   = POS_BITS'(side_eff * side_eff);
  assign delay   = POS_BITS'(hi * side_eff) + POS_BITS'(hi);

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign take       = in_fire && command == CMD_SAMPLE && !draining && in_pos < total;
  assign start_emit = out_pos < total &&
                      ((take && in_pos >= delay) ||
                       (in_fire && command == CMD_DRAIN && draining));
  assign last_out   = (out_pos + 1'b1) == total;

  // clipped window bounds
  assign r_hi     = {1'b0, out_r} + SIDE_BITS'(hi);
  assign c_hi_raw = {1'b0, out_c} + SIDE_BITS'(hi);
  assign r0 = (out_r < COL_BITS'(lo)) ? '0 : out_r - COL_BITS'(lo);
  assign c0 = (out_c < COL_BITS'(lo)) ? '0 : out_c - COL_BITS'(lo);
  assign r1 = (r_hi > side_m1) ? side_m1[COL_BITS-1:0] : r_hi[COL_BITS-1:0];
  assign c1 = (c_hi_raw > side_m1) ? side_m1[COL_BITS-1:0] : c_hi_raw[COL_BITS-1:0];
  assign nrows = 7'(r1 - r0) + 7'd1;
  assign ncols = 7'(c1 - c0) + 7'd1;
  assign area  = nrows * ncols;

  always_comb begin
    if (out_r < COL_BITS'(lo)) r0mod = '0;
    else if (out_rmod >= RMOD_BITS'(lo)) r0mod = out_rmod - RMOD_BITS'(lo);
    else r0mod = out_rmod + RMOD_BITS'(STORE_ROWS) - RMOD_BITS'(lo);
  end

  assign num = NUM_BITS'(acc) + NUM_BITS'(acc) + NUM_BITS'(cnt);

  ecbb_line_ram u_ram (
    .clk   (clk),
    .we    (take),
    .waddr ({in_rmod, in_c}),
    .wdata (height),
    .re    (state == S_SUM),
    .raddr ({cur_rmod, cur_c}),
    .rdata (rdata)
  );

  ecbb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (num),
    .den   ({cnt, 1'b0}),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      side_length  <= SIDE_BITS'(MAX_SIDE);
      window_width <= WIN_BITS'(40);
      in_pos       <= '0;
      out_pos      <= '0;
      draining     <= 1'b0;
      in_c         <= '0;
      in_rmod      <= '0;
      out_r        <= '0;
      out_c        <= '0;
      out_rmod     <= '0;
      out_valid    <= 1'b0;
      rd_valid     <= 1'b0;
      div_go       <= 1'b0;
    end else begin
      rd_valid <= (state == S_SUM);
      div_go   <= (state == S_LAST);
      if (state == S_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (cfg_write) begin
        if (cfg_index == CFG_SIDE) side_length <= cfg_data;
        else window_width <= cfg_data[WIN_BITS-1:0];
        in_pos   <= '0;
        out_pos  <= '0;
        draining <= 1'b0;
        in_c     <= '0;
        in_rmod  <= '0;
        out_r    <= '0;
        out_c    <= '0;
        out_rmod <= '0;
      end else begin
        if (take) begin
          in_pos <= in_pos + 1'b1;
          if ((in_pos + 1'b1) >= total) draining <= 1'b1;
          if ({1'b0, in_c} == side_m1) begin
            in_c    <= '0;
            in_rmod <= (in_rmod == RMOD_BITS'(STORE_ROWS - 1)) ? '0 : in_rmod + 1'b1;
          end else begin
            in_c <= in_c + 1'b1;
          end
        end
        if (state == S_OUT && (!out_valid || out_ready)) begin
          if (last_out) begin
            in_pos   <= '0;
            out_pos  <= '0;
            draining <= 1'b0;
            in_c     <= '0;
            in_rmod  <= '0;
            out_r    <= '0;
            out_c    <= '0;
            out_rmod <= '0;
          end else begin
            out_pos <= out_pos + 1'b1;
            if ({1'b0, out_c} == side_m1) begin
              out_c    <= '0;
              out_r    <= out_r + 1'b1;
              out_rmod <= (out_rmod == RMOD_BITS'(STORE_ROWS - 1)) ? '0 : out_rmod + 1'b1;
            end else begin
              out_c <= out_c + 1'b1;
            end
          end
        end
      end

      case (state)
        S_IDLE: begin
          if (start_emit) state <= S_SUM;
        end
        S_SUM: begin
          if (cur_c == c_hi && rows_left == '0) state <= S_LAST;
        end
        S_LAST: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // window walk and accumulation
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start_emit) begin
      cur_rmod  <= r0mod;
      cur_c     <= c0;
      c_lo      <= c0;
      c_hi      <= c1;
      rows_left <= nrows - 7'd1;
      cnt       <= area[CNT_BITS-1:0];
      acc       <= '0;
    end else begin
      if (state == S_SUM) begin
        if (cur_c == c_hi) begin
          cur_c     <= c_lo;
          cur_rmod  <= (cur_rmod == RMOD_BITS'(STORE_ROWS - 1)) ? '0 : cur_rmod + 1'b1;
          rows_left <= rows_left - 7'd1;
        end else begin
          cur_c <= cur_c + 1'b1;
        end
      end
      if (rd_valid) acc <= acc + SUM_BITS'(rdata);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ready)) begin
      smoothed  <= quot;
      row       <= out_r;
      column    <= out_c;
      frame_end <= last_out;
    end
  end

endmodule
